// ===== rtl/at_rlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_rlp_pkg
// Shared types and constants for the AT response line parser.
// ----------------------------------------------------------------------------
package at_rlp_pkg;

  // event bit positions
  localparam int EV_OK       = 0;
  localparam int EV_RING     = 1;
  localparam int EV_ERROR    = 2;
  localparam int EV_CLIP     = 3;
  localparam int EV_CREG     = 4;
  localparam int EV_HTTPACT  = 5;
  localparam int EV_HTTPDONE = 6;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_FIVE  = 8'h35;

  localparam logic [15:0] KW_OK         = "OK";
  localparam logic [31:0] KW_RING       = "RING";
  localparam logic [39:0] KW_ERROR      = "ERROR";
  localparam logic [39:0] KW_CLIP       = "+CLIP";
  localparam logic [39:0] KW_CREG       = "+CREG";
  localparam logic [87:0] KW_HTTPACTION = "+HTTPACTION";
  localparam logic [71:0] KW_HTTPREAD   = "+HTTPREAD";
  localparam logic [47:0] KW_SAPBR      = "+SAPBR";

  localparam int WIN_LEN = 11;

  // field offsets within a line
  localparam int OFS_CLIP_SCAN = 7;
  localparam int OFS_CREG      = 9;
  localparam int OFS_SAPBR     = 10;
  localparam int OFS_STATUS    = 14;
  localparam int OFS_LENGTH    = 18;
  localparam int OFS_COUNT     = 10;

  localparam logic [9:0] STATUS_OK = 10'd200;

  typedef enum logic [2:0] {
    CS_SEEK,
    CS_OPEN,
    CS_IN,
    CS_HIT,
    CS_MISS
  } clip_state_t;

  typedef struct packed {
    logic [6:0]  event_mask;
    logic        payload_valid;
    logic [11:0] payload_index;
    logic [7:0]  payload_byte;
    logic        registered;
    logic [9:0]  action_status;
    logic [16:0] http_length;
    logic        bearer_active;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

// ===== rtl/at_response_line_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_response_line_parser
// Parses modem response bytes into events, status fields and HTTP payload.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while in_stall is low, and yields exactly one
// registered result. Lines are never buffered: keyword hits, the first
// five bytes, the bytes at fixed offsets and the decimal fields are captured
// as each byte arrives, so the CR-LF that ends a line classifies it in the
// same cycle. A two-entry output register lets a new byte in while a result
// waits; in_stall rises only when both entries are full.
module at_response_line_parser #(
  parameter int LINE_CAPACITY    = 128,
  parameter int PAYLOAD_CAPACITY = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  event_mask,
  output logic        payload_valid,
  output logic [11:0] payload_index,
  output logic [7:0]  payload_byte,
  output logic        registered,
  output logic [9:0]  action_status,
  output logic [16:0] http_length,
  output logic        bearer_active
);
  import at_rlp_pkg::*;

  localparam int LC_W = $clog2(LINE_CAPACITY + 1);
  localparam int TG_W = $clog2(PAYLOAD_CAPACITY + 1);
  localparam logic [17:0] CAP_LIMIT = 18'(PAYLOAD_CAPACITY);

  // line state
  logic [LC_W-1:0] cnt, cnt_next;
  logic            ovf, ovf_next;
  logic [7:0]      prev, prev_next;
  logic [7:0]      hist [WIN_LEN-1];
  logic [7:0]      first [5];
  logic [7:0]      p9, p9_next, p10, p10_next;
  logic            has_clip, has_creg, has_act, has_read, has_sap;
  logic            has_clip_next, has_creg_next, has_act_next, has_read_next, has_sap_next;
  clip_state_t     clip_st, clip_st_next;
  logic [9:0]      st_val, st_val_next;
  logic            st_go, st_go_next;
  logic [16:0]     ln_val, ln_val_next, rd_val, rd_val_next;
  logic            ln_go, ln_go_next, rd_go, rd_go_next;

  // payload and status state
  logic            pmode, pmode_next;
  logic [TG_W-1:0] target, target_next, pcount, pcount_next;
  logic            reg_flag, reg_flag_next, ctx_flag, ctx_flag_next;
  logic [9:0]      status, status_next;
  logic [16:0]     dlen, dlen_next;

  // output stage
  result_t res, out_q, skid_q;
  logic    skid_v, acc, take;

  logic [WIN_LEN*8-1:0] win;
  logic                 line_end, store;
  logic [3:0]           dig;
  logic                 isd;
  logic [6:0]           ev;

  assign acc      = in_valid && !skid_v;
  assign take     = out_valid && !out_stall;
  assign in_stall = skid_v;

  always_comb begin
    win      = '0;
    win[7:0] = rx_byte;
    for (int i = 0; i < WIN_LEN - 1; i++) begin
      win[(i+1)*8 +: 8] = hist[i];
    end
  end

  assign line_end = !pmode && (rx_byte == CH_LF) && (prev == CH_CR);
  assign store    = !pmode && !line_end && (cnt < LC_W'(LINE_CAPACITY));
  assign isd      = is_digit(rx_byte);
  assign dig      = rx_byte[3:0];

  always_comb begin
    cnt_next      = cnt;
    ovf_next      = ovf;
    prev_next     = prev;
    p9_next       = p9;
    p10_next      = p10;
    has_clip_next = has_clip;
    has_creg_next = has_creg;
    has_act_next  = has_act;
    has_read_next = has_read;
    has_sap_next  = has_sap;
    clip_st_next  = clip_st;
    st_val_next   = st_val;
    st_go_next    = st_go;
    ln_val_next   = ln_val;
    ln_go_next    = ln_go;
    rd_val_next   = rd_val;
    rd_go_next    = rd_go;
    pmode_next    = pmode;
    target_next   = target;
    pcount_next   = pcount;
    reg_flag_next = reg_flag;
    ctx_flag_next = ctx_flag;
    status_next   = status;
    dlen_next     = dlen;
    ev            = '0;
    res           = '0;

    if (pmode) begin
      res.payload_valid = 1'b1;
      res.payload_index = 12'(pcount);
      res.payload_byte  = rx_byte;
      pcount_next       = pcount + 1'b1;
      if (pcount_next >= target) begin
        ev[EV_HTTPDONE] = 1'b1;
        pmode_next      = 1'b0;
        pcount_next     = '0;
      end
    end else begin
      prev_next = rx_byte;
      if (line_end) begin
        if (!ovf && cnt > LC_W'(1)) begin
          if (cnt == LC_W'(3)) begin
            ev[EV_OK] = {first[0], first[1]} == KW_OK;
          end else if (cnt == LC_W'(5)) begin
            ev[EV_RING] = {first[0], first[1], first[2], first[3]} == KW_RING;
          end else if (cnt == LC_W'(6)) begin
            ev[EV_ERROR] = {first[0], first[1], first[2], first[3], first[4]} == KW_ERROR;
          end else begin
            ev[EV_CLIP] = has_clip && (clip_st == CS_HIT);
            if (has_creg) begin
              reg_flag_next = (p9 == CH_ONE) || (p9 == CH_FIVE);
              ev[EV_CREG]   = reg_flag_next;
            end
            if (has_act) begin
              if (st_val == STATUS_OK) dlen_next = ln_val;
              status_next     = st_val;
              ev[EV_HTTPACT]  = 1'b1;
            end
            if (has_read) begin
              target_next = ({1'b0, rd_val} > CAP_LIMIT) ? TG_W'(PAYLOAD_CAPACITY)
                                                         : TG_W'(rd_val);
              pcount_next = '0;
              if (target_next == '0) ev[EV_HTTPDONE] = 1'b1;
              else pmode_next = 1'b1;
            end
            if (has_sap) ctx_flag_next = (p10 == CH_ONE);
          end
        end
        // start a fresh line
        cnt_next      = '0;
        ovf_next      = 1'b0;
        p9_next       = '0;
        p10_next      = '0;
        has_clip_next = 1'b0;
        has_creg_next = 1'b0;
        has_act_next  = 1'b0;
        has_read_next = 1'b0;
        has_sap_next  = 1'b0;
        clip_st_next  = CS_SEEK;
        st_val_next   = '0;
        st_go_next    = 1'b0;
        ln_val_next   = '0;
        ln_go_next    = 1'b0;
        rd_val_next   = '0;
        rd_go_next    = 1'b0;
      end else if (store) begin
        cnt_next = cnt + 1'b1;
        if (cnt == LC_W'(OFS_CREG))  p9_next  = rx_byte;
        if (cnt == LC_W'(OFS_SAPBR)) p10_next = rx_byte;
        if (win[39:0] == KW_CLIP)      has_clip_next = 1'b1;
        if (win[39:0] == KW_CREG)      has_creg_next = 1'b1;
        if (win[87:0] == KW_HTTPACTION) has_act_next = 1'b1;
        if (win[71:0] == KW_HTTPREAD)  has_read_next = 1'b1;
        if (win[47:0] == KW_SAPBR)     has_sap_next  = 1'b1;
        if (cnt >= LC_W'(OFS_CLIP_SCAN)) begin
          case (clip_st)
            CS_SEEK: if (rx_byte == CH_QUOTE) clip_st_next = CS_OPEN;
            CS_OPEN: clip_st_next = (rx_byte == CH_QUOTE) ? CS_MISS : CS_IN;
            CS_IN:   if (rx_byte == CH_QUOTE) clip_st_next = CS_HIT;
            default: clip_st_next = clip_st;
          endcase
        end
        // decimal fields, stopping at the first non-digit
        if (cnt == LC_W'(OFS_STATUS)) begin
          st_go_next  = isd;
          st_val_next = isd ? 10'(dig) : '0;
        end else if (cnt > LC_W'(OFS_STATUS) && cnt < LC_W'(OFS_STATUS + 3)) begin
          if (st_go && isd) st_val_next = 10'(st_val * 10) + 10'(dig);
          else st_go_next = 1'b0;
        end
        if (cnt == LC_W'(OFS_LENGTH)) begin
          ln_go_next  = isd;
          ln_val_next = isd ? 17'(dig) : '0;
        end else if (cnt > LC_W'(OFS_LENGTH) && cnt < LC_W'(OFS_LENGTH + 5)) begin
          if (ln_go && isd) ln_val_next = 17'(ln_val * 10) + 17'(dig);
          else ln_go_next = 1'b0;
        end
        if (cnt == LC_W'(OFS_COUNT)) begin
          rd_go_next  = isd;
          rd_val_next = isd ? 17'(dig) : '0;
        end else if (cnt > LC_W'(OFS_COUNT) && cnt < LC_W'(OFS_COUNT + 5)) begin
          if (rd_go && isd) rd_val_next = 17'(rd_val * 10) + 17'(dig);
          else rd_go_next = 1'b0;
        end
      end else begin
        ovf_next = 1'b1;
      end
    end

    res.event_mask    = ev;
    res.registered    = reg_flag_next;
    res.action_status = status_next;
    res.http_length   = dlen_next;
    res.bearer_active = ctx_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      ovf      <= 1'b0;
      prev     <= '0;
      p9       <= '0;
      p10      <= '0;
      has_clip <= 1'b0;
      has_creg <= 1'b0;
      has_act  <= 1'b0;
      has_read <= 1'b0;
      has_sap  <= 1'b0;
      clip_st  <= CS_SEEK;
      st_val   <= '0;
      st_go    <= 1'b0;
      ln_val   <= '0;
      ln_go    <= 1'b0;
      rd_val   <= '0;
      rd_go    <= 1'b0;
      pmode    <= 1'b0;
      target   <= '0;
      pcount   <= '0;
      reg_flag <= 1'b0;
      ctx_flag <= 1'b0;
      status   <= '0;
      dlen     <= '0;
      for (int i = 0; i < WIN_LEN - 1; i++) hist[i] <= '0;
    end else if (acc) begin
      cnt      <= cnt_next;
      ovf      <= ovf_next;
      prev     <= prev_next;
      p9       <= p9_next;
      p10      <= p10_next;
      has_clip <= has_clip_next;
      has_creg <= has_creg_next;
      has_act  <= has_act_next;
      has_read <= has_read_next;
      has_sap  <= has_sap_next;
      clip_st  <= clip_st_next;
      st_val   <= st_val_next;
      st_go    <= st_go_next;
      ln_val   <= ln_val_next;
      ln_go    <= ln_go_next;
      rd_val   <= rd_val_next;
      rd_go    <= rd_go_next;
      pmode    <= pmode_next;
      target   <= target_next;
      pcount   <= pcount_next;
      reg_flag <= reg_flag_next;
      ctx_flag <= ctx_flag_next;
      status   <= status_next;
      dlen     <= dlen_next;
      // keyword window never spans two lines
      if (line_end) begin
        for (int i = 0; i < WIN_LEN - 1; i++) hist[i] <= '0;
      end else if (store) begin
        hist[0] <= rx_byte;
        for (int i = 1; i < WIN_LEN - 1; i++) hist[i] <= hist[i-1];
      end
    end
  end

  // first five bytes of the line, checked only against the line length
  always_ff @(posedge clk) begin
    if (acc && store) begin
      for (int i = 0; i < 5; i++) begin
        if (cnt == LC_W'(i)) first[i] <= rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (acc) begin
      if (!out_valid || take) begin
        out_q     <= res;
        out_valid <= 1'b1;
      end else begin
        skid_q <= res;
        skid_v <= 1'b1;
      end
    end else if (take) begin
      if (skid_v) begin
        out_q  <= skid_q;
        skid_v <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign event_mask    = out_q.event_mask;
  assign payload_valid = out_q.payload_valid;
  assign payload_index = out_q.payload_index;
  assign payload_byte  = out_q.payload_byte;
  assign registered    = out_q.registered;
  assign action_status = out_q.action_status;
  assign http_length   = out_q.http_length;
  assign bearer_active = out_q.bearer_active;

endmodule

// ===== rtl/at_rlp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_rlp_checker
// Port-level checks for the AT response line parser, bound to the top level.
// ----------------------------------------------------------------------------
module at_rlp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [6:0]  event_mask,
  input logic        payload_valid,
  input logic [11:0] payload_index,
  input logic [7:0]  payload_byte
);
  import at_rlp_pkg::*;

  // a non-payload request carries a zero index and byte
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !payload_valid |-> payload_index == '0 && payload_byte == '0)
    else $error("payload fields set without payload_valid");

  // a payload byte can only finish a read, never classify a line
  a_payload_events: assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_valid |-> event_mask[EV_HTTPACT:EV_OK] == '0)
    else $error("line event on a payload byte");

  // exact-line events exclude each other and the keyword events
  a_exact_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_mask[EV_ERROR:EV_OK] != '0 |->
      $onehot(event_mask[EV_ERROR:EV_OK]) && event_mask[EV_HTTPDONE:EV_CLIP] == '0)
    else $error("exact-line event mixed with other events");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_mask) && $stable(payload_index))
    else $error("stalled result changed");

endmodule

bind at_response_line_parser at_rlp_checker u_at_rlp_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .event_mask    (event_mask),
  .payload_valid (payload_valid),
  .payload_index (payload_index),
  .payload_byte  (payload_byte)
);
